@@ sv/imutcf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imutcf_pkg
// Shared types, constants and the arctangent table of the tilt filter.
// ----------------------------------------------------------------------------
package imutcf_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int CORDIC_MAX       = 24;
	localparam int SQRT_STEPS       = 16;
	// divide by 1000: 64-bit dividend, 16 bits retired per step
	localparam int DIV_BITS         = 64;
	localparam int DIV_STEPS        = 4;
	localparam int CNT_W            = 6;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_ROLL_OFF   = 3'd0,
		REG_PITCH_OFF  = 3'd1,
		REG_RATE_OFF_X = 3'd2,
		REG_RATE_OFF_Y = 3'd3,
		REG_RATE_OFF_Z = 3'd4,
		REG_RATE_SCALE = 3'd5,
		REG_GYRO_W     = 3'd6
	} cfg_reg_t;

	// datapath micro-operations
	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_SQ, OP_SQRT, OP_CINIT, OP_CSTEP, OP_ANGLE,
		OP_RMUL, OP_RATE, OP_IMUL, OP_DINIT, OP_DSTEP, OP_ACC,
		OP_BLO, OP_BHI, OP_BA, OP_BSUM, OP_YAW
	} dp_op_t;

	typedef struct packed {
		dp_op_t      op;
		logic [1:0]  axis;
		logic [4:0]  step;
	} dp_cmd_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SQ, ST_SQRT, ST_CINIT, ST_CORDIC, ST_ANGLE,
		ST_RMUL, ST_RATE, ST_IMUL, ST_DINIT, ST_DIV, ST_ACC,
		ST_BLO, ST_BHI, ST_BA, ST_BSUM, ST_YAW, ST_DONE
	} ctrl_state_t;

	// atan(2^-i) in 1/65536 degree
	function automatic logic [21:0] atan_lut(input logic [4:0] i);
		logic [21:0] v;
		case (i)
			5'd0:  v = 22'd2949120;
			5'd1:  v = 22'd1740967;
			5'd2:  v = 22'd919879;
			5'd3:  v = 22'd466945;
			5'd4:  v = 22'd234379;
			5'd5:  v = 22'd117304;
			5'd6:  v = 22'd58666;
			5'd7:  v = 22'd29335;
			5'd8:  v = 22'd14668;
			5'd9:  v = 22'd7334;
			5'd10: v = 22'd3667;
			5'd11: v = 22'd1833;
			5'd12: v = 22'd917;
			5'd13: v = 22'd458;
			5'd14: v = 22'd229;
			5'd15: v = 22'd115;
			5'd16: v = 22'd57;
			5'd17: v = 22'd29;
			5'd18: v = 22'd14;
			5'd19: v = 22'd7;
			5'd20: v = 22'd4;
			5'd21: v = 22'd2;
			5'd22: v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage

@@ sv/imu_tilt_complementary_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_tilt_complementary_filter
// Roll/pitch/yaw complementary filter over one accel and gyro sample each.
// ----------------------------------------------------------------------------
// The run time is set by the one-bit-a-cycle square root, the CORDIC iterations
// and the four-digit divide by 1000 per gyro axis.
// One sample in flight: a new sample is accepted only after the result is taken.
// Reset: arst_n clears the controller and the three angle accumulators and
// loads the configuration registers with their defaults.
module imu_tilt_complementary_filter #(
	parameter int CORDIC_STEPS = imutcf_pkg::CORDIC_STEPS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, elapsed_ms
	input  logic [111:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// roll_angle, pitch_angle, yaw_angle, accel_roll, accel_pitch, zero pad
	output logic [135:0] m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [16:0]  cfg_data
);

	imutcf_pkg::dp_cmd_t cmd;
	logic signed [31:0]  roll, pitch, yaw;
	logic signed [16:0]  aroll, apitch;

	assign cfg_ready = 1'b1;

	imutcf_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	imutcf_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_idx     (cfg_index),
		.cfg_val     (cfg_data),
		.in_ax       (s_tdata[15:0]),
		.in_ay       (s_tdata[31:16]),
		.in_az       (s_tdata[47:32]),
		.in_gx       (s_tdata[63:48]),
		.in_gy       (s_tdata[79:64]),
		.in_gz       (s_tdata[95:80]),
		.in_ms       (s_tdata[111:96]),
		.roll_angle  (roll),
		.pitch_angle (pitch),
		.yaw_angle   (yaw),
		.accel_roll  (aroll),
		.accel_pitch (apitch)
	);

	assign m_tdata = {6'd0, apitch, aroll, yaw, pitch, roll};

	// one sample at a time: never ready while a result is held
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("ready while result pending");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready) else $error("ready right after transfer");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |=> s_tready) else $error("not ready after result transfer");

endmodule

@@ sv/imutcf_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imutcf_ctrl
// Sequencer: steps the datapath through square root, CORDIC, rate
// integration and blend for each sample.
// ----------------------------------------------------------------------------
module imutcf_ctrl #(
	parameter int CORDIC_STEPS = imutcf_pkg::CORDIC_STEPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output imutcf_pkg::dp_cmd_t cmd
);

	localparam int CNT_W = imutcf_pkg::CNT_W;
	localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(imutcf_pkg::SQRT_STEPS - 1);
	localparam logic [CNT_W-1:0] CORD_LAST = CNT_W'(CORDIC_STEPS - 1);
	localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(imutcf_pkg::DIV_STEPS - 1);

	imutcf_pkg::ctrl_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [1:0]       axis_q, axis_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= imutcf_pkg::ST_IDLE;
			cnt_q   <= '0;
			axis_q  <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			axis_q  <= axis_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		axis_d    = axis_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd.op    = imutcf_pkg::OP_NONE;
		cmd.axis  = axis_q;
		cmd.step  = cnt_q[4:0];
		case (state_q)
			imutcf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = imutcf_pkg::OP_LOAD;
					axis_d  = 2'd0;
					state_d = imutcf_pkg::ST_SQ;
				end
			end
			imutcf_pkg::ST_SQ: begin
				cmd.op  = imutcf_pkg::OP_SQ;
				cnt_d   = '0;
				state_d = imutcf_pkg::ST_SQRT;
			end
			imutcf_pkg::ST_SQRT: begin
				cmd.op = imutcf_pkg::OP_SQRT;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == SQRT_LAST) state_d = imutcf_pkg::ST_CINIT;
			end
			imutcf_pkg::ST_CINIT: begin
				cmd.op  = imutcf_pkg::OP_CINIT;
				cnt_d   = '0;
				state_d = imutcf_pkg::ST_CORDIC;
			end
			imutcf_pkg::ST_CORDIC: begin
				cmd.op = imutcf_pkg::OP_CSTEP;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == CORD_LAST) state_d = imutcf_pkg::ST_ANGLE;
			end
			imutcf_pkg::ST_ANGLE: begin
				cmd.op = imutcf_pkg::OP_ANGLE;
				if (axis_q == 2'd0) begin
					axis_d  = 2'd1;
					state_d = imutcf_pkg::ST_SQ;
				end else begin
					axis_d  = 2'd0;
					state_d = imutcf_pkg::ST_RMUL;
				end
			end
			imutcf_pkg::ST_RMUL: begin
				cmd.op  = imutcf_pkg::OP_RMUL;
				state_d = imutcf_pkg::ST_RATE;
			end
			imutcf_pkg::ST_RATE: begin
				cmd.op  = imutcf_pkg::OP_RATE;
				state_d = imutcf_pkg::ST_IMUL;
			end
			imutcf_pkg::ST_IMUL: begin
				cmd.op  = imutcf_pkg::OP_IMUL;
				state_d = imutcf_pkg::ST_DINIT;
			end
			imutcf_pkg::ST_DINIT: begin
				cmd.op  = imutcf_pkg::OP_DINIT;
				cnt_d   = '0;
				state_d = imutcf_pkg::ST_DIV;
			end
			imutcf_pkg::ST_DIV: begin
				cmd.op = imutcf_pkg::OP_DSTEP;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == DIV_LAST) state_d = imutcf_pkg::ST_ACC;
			end
			imutcf_pkg::ST_ACC: begin
				cmd.op = imutcf_pkg::OP_ACC;
				if (axis_q == 2'd2) begin
					axis_d  = 2'd0;
					state_d = imutcf_pkg::ST_BLO;
				end else begin
					axis_d  = axis_q + 1'b1;
					state_d = imutcf_pkg::ST_RMUL;
				end
			end
			imutcf_pkg::ST_BLO: begin
				cmd.op  = imutcf_pkg::OP_BLO;
				state_d = imutcf_pkg::ST_BHI;
			end
			imutcf_pkg::ST_BHI: begin
				cmd.op  = imutcf_pkg::OP_BHI;
				state_d = imutcf_pkg::ST_BA;
			end
			imutcf_pkg::ST_BA: begin
				cmd.op  = imutcf_pkg::OP_BA;
				state_d = imutcf_pkg::ST_BSUM;
			end
			imutcf_pkg::ST_BSUM: begin
				cmd.op = imutcf_pkg::OP_BSUM;
				if (axis_q == 2'd1) begin
					state_d = imutcf_pkg::ST_YAW;
				end else begin
					axis_d  = 2'd1;
					state_d = imutcf_pkg::ST_BLO;
				end
			end
			imutcf_pkg::ST_YAW: begin
				cmd.op  = imutcf_pkg::OP_YAW;
				state_d = imutcf_pkg::ST_DONE;
			end
			imutcf_pkg::ST_DONE: begin
				out_valid = 1'b1;
				if (out_ready) state_d = imutcf_pkg::ST_IDLE;
			end
			default: state_d = imutcf_pkg::ST_IDLE;
		endcase
	end

endmodule

@@ sv/imutcf_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imutcf_dp
// Datapath: config registers, square root, CORDIC, rate integration with
// divide by 1000, accumulators and blend multipliers.
// ----------------------------------------------------------------------------
module imutcf_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  imutcf_pkg::dp_cmd_t cmd,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_idx,
	input  logic [16:0]         cfg_val,
	input  logic signed [15:0]  in_ax,
	input  logic signed [15:0]  in_ay,
	input  logic signed [15:0]  in_az,
	input  logic signed [15:0]  in_gx,
	input  logic signed [15:0]  in_gy,
	input  logic signed [15:0]  in_gz,
	input  logic [15:0]         in_ms,
	output logic signed [31:0]  roll_angle,
	output logic signed [31:0]  pitch_angle,
	output logic signed [31:0]  yaw_angle,
	output logic signed [16:0]  accel_roll,
	output logic signed [16:0]  accel_pitch
);

	localparam int DB = imutcf_pkg::DIV_BITS;
	// ceil(2^36 / 1000): exact quotient for any dividend below 2^26
	localparam logic [26:0] RECIP_1000 = 27'd68719477;

	// configuration
	logic signed [15:0] roll_off_q, pitch_off_q;
	logic signed [16:0] roff_x_q, roff_y_q, roff_z_q;
	logic [15:0]        scale_q;
	logic [16:0]        gw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_off_q  <= 16'sd1500;
			pitch_off_q <= 16'sd19297;
			roff_x_q    <= 17'sd159;
			roff_y_q    <= 17'sd74;
			roff_z_q    <= -17'sd205;
			scale_q     <= 16'd500;
			gw_q        <= 17'd64225;
		end else if (cfg_we) begin
			case (imutcf_pkg::cfg_reg_t'(cfg_idx))
				imutcf_pkg::REG_ROLL_OFF:   roll_off_q  <= cfg_val[15:0];
				imutcf_pkg::REG_PITCH_OFF:  pitch_off_q <= cfg_val[15:0];
				imutcf_pkg::REG_RATE_OFF_X: roff_x_q    <= cfg_val;
				imutcf_pkg::REG_RATE_OFF_Y: roff_y_q    <= cfg_val;
				imutcf_pkg::REG_RATE_OFF_Z: roff_z_q    <= cfg_val;
				imutcf_pkg::REG_RATE_SCALE: scale_q     <= cfg_val[15:0];
				imutcf_pkg::REG_GYRO_W:     gw_q        <= cfg_val;
				default: ;
			endcase
		end
	end

	// working registers
	logic signed [15:0] ax_q, ay_q, az_q, gx_q, gy_q, gz_q;
	logic [15:0]        ms_q;
	logic [31:0]        n_q, res_q, bit_q;
	logic signed [26:0] x_q, y_q;
	logic signed [24:0] z_q;
	logic signed [16:0] num_q;
	logic signed [16:0] aroll_q, apitch_q;
	logic signed [32:0] p_q;
	logic signed [26:0] r_q;
	logic signed [43:0] prod_q;
	logic [DB-1:0]      u_q;
	logic [9:0]         rem_q;
	logic               neg_q;
	logic signed [47:0] acc_x_q, acc_y_q, acc_z_q;
	logic [40:0]        plo_q;
	logic signed [41:0] phi_q;
	logic signed [34:0] pa_q;
	logic signed [31:0] roll_q, pitch_q, yaw_q;

	// combinational helpers
	logic signed [15:0] sq_a;
	logic signed [31:0] sq_p0, sq_p1;
	logic [32:0]        sq_trial;
	logic signed [16:0] c_num;
	logic signed [26:0] c_dx, c_dy;
	logic signed [24:0] c_at;
	logic signed [25:0] a_zr;
	logic signed [17:0] a_ang;
	logic signed [18:0] a_sub;
	logic signed [16:0] a_res;
	logic signed [15:0] g_raw;
	logic signed [16:0] g_off;
	logic signed [33:0] r_sum;
	logic signed [52:0] d_t;
	logic [25:0]        d_cat;
	logic [51:0]        d_prod;
	logic [15:0]        d_quo;
	logic [25:0]        d_back;
	logic signed [53:0] q_inc, q_sum;
	logic signed [47:0] q_new;
	logic signed [47:0] acc_sel;
	logic [16:0]        w_eff;
	logic signed [16:0] b_accel;
	logic signed [67:0] b_sum;
	logic signed [43:0] b_sh;
	logic signed [31:0] b_res;
	logic signed [48:0] y_sum;
	logic signed [40:0] y_sh;
	logic signed [31:0] y_res;

	always_comb begin
		// square sum operands
		sq_a     = (cmd.axis == 2'd0) ? ax_q : ay_q;
		sq_p0    = sq_a * sq_a;
		sq_p1    = az_q * az_q;
		sq_trial = {1'b0, res_q} + {1'b0, bit_q};
		// cordic
		c_num = (cmd.axis == 2'd0) ? 17'(ay_q) : -17'(ax_q);
		c_dx  = y_q >>> cmd.step;
		c_dy  = x_q >>> cmd.step;
		c_at  = 25'(signed'({1'b0, imutcf_pkg::atan_lut(cmd.step)}));
		// angle round, clamp, offset
		a_zr = (26'(z_q) + 26'sd128) >>> 8;
		if (a_zr > 26'sd23040)       a_ang = 18'sd23040;
		else if (a_zr < -26'sd23040) a_ang = -18'sd23040;
		else                         a_ang = 18'(a_zr);
		if (num_q == 17'sd0) a_ang = 18'sd0;
		a_sub = 19'(a_ang) - ((cmd.axis == 2'd0) ? 19'(roll_off_q) : 19'(pitch_off_q));
		if (a_sub > 19'sd46080)       a_res = 17'sd46080;
		else if (a_sub < -19'sd46080) a_res = -17'sd46080;
		else                          a_res = 17'(a_sub);
		// gyro axis select
		case (cmd.axis)
			2'd0: begin g_raw = gx_q; g_off = roff_x_q; acc_sel = acc_x_q; end
			2'd1: begin g_raw = gy_q; g_off = roff_y_q; acc_sel = acc_y_q; end
			default: begin g_raw = gz_q; g_off = roff_z_q; acc_sel = acc_z_q; end
		endcase
		r_sum = 34'(p_q) + 34'sd128;
		// dividend for divide by 1000
		d_t   = (53'(prod_q) <<< 8) + 53'sd500;
		// one 16-bit digit of the divide: reciprocal multiply, then remainder
		d_cat  = {rem_q, u_q[DB-1 -: 16]};
		d_prod = 52'(d_cat) * 52'(RECIP_1000);
		d_quo  = d_prod[51:36];
		d_back = d_cat - 26'(d_quo) * 26'd1000;
		// accumulate with saturation
		q_inc = neg_q ? -54'(signed'({1'b0, u_q})) : 54'(signed'({1'b0, u_q}));
		q_sum = 54'(acc_sel) + q_inc;
		if (q_sum > 54'sh7FFF_FFFF_FFFF)       q_new = 48'sh7FFF_FFFF_FFFF;
		else if (q_sum < -54'sh8000_0000_0000) q_new = -48'sh8000_0000_0000;
		else                                   q_new = 48'(q_sum);
		// blend
		w_eff   = (gw_q > 17'd65536) ? 17'd65536 : gw_q;
		b_accel = (cmd.axis == 2'd0) ? aroll_q : apitch_q;
		b_sum   = (68'(phi_q) <<< 24) + 68'(signed'({1'b0, plo_q}))
		        + (68'(pa_q) <<< 8) + 68'sd8388608;
		b_sh    = 44'(b_sum >>> 24);
		if (b_sh > 44'sd2147483647)       b_res = 32'sh7FFF_FFFF;
		else if (b_sh < -44'sd2147483648) b_res = 32'sh8000_0000;
		else                              b_res = 32'(b_sh);
		// yaw
		y_sum = 49'(acc_z_q) + 49'sd128;
		y_sh  = 41'(y_sum >>> 8);
		if (y_sh > 41'sd2147483647)       y_res = 32'sh7FFF_FFFF;
		else if (y_sh < -41'sd2147483648) y_res = 32'sh8000_0000;
		else                              y_res = 32'(y_sh);
	end

	// accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
			acc_z_q <= '0;
		end else if (cmd.op == imutcf_pkg::OP_ACC) begin
			case (cmd.axis)
				2'd0:    acc_x_q <= q_new;
				2'd1:    acc_y_q <= q_new;
				default: acc_z_q <= q_new;
			endcase
		end
	end

	// datapath operations
	always_ff @(posedge clk) begin
		case (cmd.op)
			imutcf_pkg::OP_LOAD: begin
				ax_q <= in_ax; ay_q <= in_ay; az_q <= in_az;
				gx_q <= in_gx; gy_q <= in_gy; gz_q <= in_gz;
				ms_q <= in_ms;
			end
			imutcf_pkg::OP_SQ: begin
				n_q   <= $unsigned(sq_p0) + $unsigned(sq_p1);
				res_q <= '0;
				bit_q <= 32'h4000_0000;
			end
			imutcf_pkg::OP_SQRT: begin
				if ({1'b0, n_q} >= sq_trial) begin
					n_q   <= n_q - sq_trial[31:0];
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			imutcf_pkg::OP_CINIT: begin
				x_q   <= 27'(signed'({1'b0, res_q[15:0], 8'd0}));
				y_q   <= 27'(c_num) <<< 8;
				z_q   <= '0;
				num_q <= c_num;
			end
			imutcf_pkg::OP_CSTEP: begin
				if (y_q > 27'sd0) begin
					x_q <= x_q + c_dx; y_q <= y_q - c_dy; z_q <= z_q + c_at;
				end else if (y_q < 27'sd0) begin
					x_q <= x_q - c_dx; y_q <= y_q + c_dy; z_q <= z_q - c_at;
				end
			end
			imutcf_pkg::OP_ANGLE: begin
				if (cmd.axis == 2'd0) aroll_q <= a_res;
				else                  apitch_q <= a_res;
			end
			imutcf_pkg::OP_RMUL: p_q <= g_raw * signed'({1'b0, scale_q});
			imutcf_pkg::OP_RATE: r_q <= 27'(r_sum >>> 8) - 27'(g_off);
			imutcf_pkg::OP_IMUL: prod_q <= r_q * signed'({1'b0, ms_q});
			imutcf_pkg::OP_DINIT: begin
				neg_q <= d_t[52];
				u_q   <= d_t[52] ? DB'(-d_t + 53'sd999) : DB'(d_t);
				rem_q <= '0;
			end
			imutcf_pkg::OP_DSTEP: begin
				rem_q <= d_back[9:0];
				u_q   <= {u_q[DB-17:0], d_quo};
			end
			imutcf_pkg::OP_BLO: plo_q <= w_eff * acc_sel[23:0];
			imutcf_pkg::OP_BHI: phi_q <= signed'({1'b0, w_eff}) * signed'(acc_sel[47:24]);
			imutcf_pkg::OP_BA:  pa_q <= signed'({1'b0, 17'd65536 - w_eff}) * b_accel;
			imutcf_pkg::OP_BSUM: begin
				if (cmd.axis == 2'd0) roll_q <= b_res;
				else                  pitch_q <= b_res;
			end
			imutcf_pkg::OP_YAW: yaw_q <= y_res;
			default: ;
		endcase
	end

	assign roll_angle  = roll_q;
	assign pitch_angle = pitch_q;
	assign yaw_angle   = yaw_q;
	assign accel_roll  = aroll_q;
	assign accel_pitch = apitch_q;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tilt complementary filter. Samples are pushed
// through the input stream with random gaps and the results are drained with
// random back-pressure. A scoreboard class predicts roll, pitch, yaw and the
// accel angles bit for bit and checks every result transfer in order.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int LATENCY = 260;
	localparam int STEPS   = imutcf_pkg::CORDIC_STEPS_DEF;

	typedef struct {
		logic signed [15:0] ax, ay, az, rx, ry, rz;
		logic        [15:0] ms;
	} sample_t;

	// scoreboard: filter predictor plus queue of expected results
	class tilt_scoreboard;
		logic signed [15:0] roll_off, pitch_off;
		logic signed [16:0] rate_off [3];
		logic        [15:0] scale;
		logic        [16:0] weight;
		longint             acc [3];
		logic [129:0]       want_q [$];
		int                 errors;
		longint             atan_deg [24];

		function new();
			atan_deg = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
				29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7,
				4, 2, 1, 0};
			errors = 0;
			roll_off = 16'sd1500;
			pitch_off = 16'sd19297;
			rate_off = '{17'sd159, 17'sd74, -17'sd205};
			scale = 16'd500;
			weight = 17'd64225;
			acc = '{0, 0, 0};
		endfunction

		function void write_reg(imutcf_pkg::cfg_reg_t idx, logic [16:0] v);
			case (idx)
				imutcf_pkg::REG_ROLL_OFF:   roll_off = v[15:0];
				imutcf_pkg::REG_PITCH_OFF:  pitch_off = v[15:0];
				imutcf_pkg::REG_RATE_OFF_X: rate_off[0] = v;
				imutcf_pkg::REG_RATE_OFF_Y: rate_off[1] = v;
				imutcf_pkg::REG_RATE_OFF_Z: rate_off[2] = v;
				imutcf_pkg::REG_RATE_SCALE: scale = v[15:0];
				imutcf_pkg::REG_GYRO_W:     weight = v;
				default: ;
			endcase
		endfunction

		function longint clip(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function longint int_sqrt(longint unsigned n);
			longint unsigned res, bit_w;
			res = 0;
			bit_w = 64'd1 << 62;
			while (bit_w > n)
				bit_w >>= 2;
			while (bit_w != 0) begin
				if (n >= res + bit_w) begin
					n -= res + bit_w;
					res = (res >> 1) + bit_w;
				end else begin
					res >>= 1;
				end
				bit_w >>= 2;
			end
			return longint'(res);
		endfunction

		// CORDIC vectoring, result in 1/256 degree
		function longint tilt_angle(longint num, longint den);
			longint xc, yc, z, dx, dy;
			xc = den * 256;
			yc = num * 256;
			z = 0;
			if (num == 0)
				return 0;
			for (int i = 0; i < STEPS && i < 24; i++) begin
				dx = yc >>> i;
				dy = xc >>> i;
				if (yc > 0) begin
					xc += dx; yc -= dy; z += atan_deg[i];
				end else if (yc < 0) begin
					xc -= dx; yc += dy; z -= atan_deg[i];
				end
			end
			return clip((z + 128) >>> 8, -23040, 23040);
		endfunction

		function longint gyro_rate(logic signed [15:0] raw, logic signed [16:0] off);
			longint p;
			p = longint'(raw) * longint'({1'b0, scale});
			return ((p + 128) >>> 8) - longint'(off);
		endfunction

		function longint step_acc(longint a, longint r, longint ms);
			longint t, inc;
			t = r * ms * 256 + 500;
			if (t >= 0)
				inc = t / 1000;
			else
				inc = -((-t + 999) / 1000);
			return clip(a + inc, -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
		endfunction

		function longint mix(longint a, longint accel, longint w);
			longint g, s;
			g = w * a;
			s = (65536 - w) * (accel * 256);
			return clip((g + s + (64'sd1 <<< 23)) >>> 24, -64'sd2147483648, 64'sd2147483647);
		endfunction

		function void note_sample(sample_t s);
			longint ax, ay, az, w, aroll, apitch, ms;
			logic [31:0] roll, pitch, yaw;
			logic [16:0] ar, ap;
			ax = s.ax; ay = s.ay; az = s.az;
			ms = longint'({48'd0, s.ms});
			w = weight > 17'd65536 ? 65536 : longint'({47'd0, weight});
			aroll = clip(tilt_angle(ay, int_sqrt(ax * ax + az * az)) - longint'(roll_off),
				-46080, 46080);
			apitch = clip(tilt_angle(-ax, int_sqrt(ay * ay + az * az)) - longint'(pitch_off),
				-46080, 46080);
			acc[0] = step_acc(acc[0], gyro_rate(s.rx, rate_off[0]), ms);
			acc[1] = step_acc(acc[1], gyro_rate(s.ry, rate_off[1]), ms);
			acc[2] = step_acc(acc[2], gyro_rate(s.rz, rate_off[2]), ms);
			roll = 32'(mix(acc[0], aroll, w));
			pitch = 32'(mix(acc[1], apitch, w));
			yaw = 32'(clip((acc[2] + 128) >>> 8, -64'sd2147483648, 64'sd2147483647));
			ar = 17'(aroll);
			ap = 17'(apitch);
			want_q.push_back({ap, ar, yaw, pitch, roll});
		endfunction

		function void check_result(logic [135:0] d);
			logic [129:0] want;
			longint e [5], g [5];
			string nm [5];
			nm = '{"roll_angle", "pitch_angle", "yaw_angle", "accel_roll", "accel_pitch"};
			if (want_q.size() == 0) begin
				$display("%0t unexpected result transfer %h", $time, d);
				errors++;
				return;
			end
			want = want_q.pop_front();
			e[0] = $signed(want[31:0]);    g[0] = $signed(d[31:0]);
			e[1] = $signed(want[63:32]);   g[1] = $signed(d[63:32]);
			e[2] = $signed(want[95:64]);   g[2] = $signed(d[95:64]);
			e[3] = $signed(want[112:96]);  g[3] = $signed(d[112:96]);
			e[4] = $signed(want[129:113]); g[4] = $signed(d[129:113]);
			for (int i = 0; i < 5; i++)
				if (e[i] != g[i]) begin
					$display("%0t %s: expected %0d actual %0d", $time, nm[i], e[i], g[i]);
					errors++;
				end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [111:0]         s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [135:0]         m_tdata;
	logic                 cfg_valid;
	logic                 cfg_ready;
	imutcf_pkg::cfg_reg_t cfg_index;
	logic [16:0]          cfg_data;

	tilt_scoreboard sb;
	bit             quiet;

	imu_tilt_complementary_filter DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

	// result side: random back-pressure unless quiet, check every transfer
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				sb.check_result(m_tdata);
			m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 38);
		end
	end

	task automatic write_reg(imutcf_pkg::cfg_reg_t idx, logic [16:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, v);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all(logic [16:0] roll, logic [16:0] pitch, logic [16:0] ox,
		logic [16:0] oy, logic [16:0] oz, logic [16:0] sc, logic [16:0] w);
		write_reg(imutcf_pkg::REG_ROLL_OFF, roll);
		write_reg(imutcf_pkg::REG_PITCH_OFF, pitch);
		write_reg(imutcf_pkg::REG_RATE_OFF_X, ox);
		write_reg(imutcf_pkg::REG_RATE_OFF_Y, oy);
		write_reg(imutcf_pkg::REG_RATE_OFF_Z, oz);
		write_reg(imutcf_pkg::REG_RATE_SCALE, sc);
		write_reg(imutcf_pkg::REG_GYRO_W, w);
	endtask

	// one sample transfer, optional random gap in front
	task automatic send_sample(sample_t s);
		while (!quiet && $urandom_range(99) < 38) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {s.ms, s.rz, s.ry, s.rx, s.az, s.ay, s.ax};
		do @(posedge clk); while (!s_tready);
		sb.note_sample(s);
	endtask

	task automatic send_fields(int ax, int ay, int az, int rx, int ry, int rz, int ms);
		sample_t s;
		s.ax = 16'(ax); s.ay = 16'(ay); s.az = 16'(az);
		s.rx = 16'(rx); s.ry = 16'(ry); s.rz = 16'(rz);
		s.ms = 16'(ms);
		send_sample(s);
	endtask

	// mostly a plausible tilt with small rates, some full-range noise
	function automatic sample_t rand_sample();
		sample_t s;
		if ($urandom_range(99) < 65) begin
			s.ax = 16'($urandom_range(40000) - 20000);
			s.ay = 16'($urandom_range(40000) - 20000);
			s.az = 16'($urandom_range(40000) - 20000);
			s.rx = 16'($urandom_range(4000) - 2000);
			s.ry = 16'($urandom_range(4000) - 2000);
			s.rz = 16'($urandom_range(4000) - 2000);
			s.ms = 16'($urandom_range(60));
		end else begin
			s.ax = 16'($urandom); s.ay = 16'($urandom); s.az = 16'($urandom);
			s.rx = 16'($urandom); s.ry = 16'($urandom); s.rz = 16'($urandom);
			s.ms = 16'($urandom);
		end
		return s;
	endfunction

	task automatic send_random(int n);
		for (int i = 0; i < n; i++)
			send_sample(rand_sample());
		s_tvalid <= 1'b0;
	endtask

	// hold off until every result is back, then let the pipeline settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.want_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic rand_config();
		write_all(17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom),
			17'($urandom), 17'($urandom_range(65535, 1)), 17'($urandom_range(65536)));
	endtask

	initial begin
		sb = new();
		quiet = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = imutcf_pkg::REG_ROLL_OFF;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: defaults, field extremes, zero numerators, zero elapsed time
		send_fields(0, 0, 0, 0, 0, 0, 0);
		send_fields(32767, 32767, 32767, 32767, 32767, 32767, 65535);
		send_fields(-32768, -32768, -32768, -32768, -32768, -32768, 65535);
		send_fields(0, 16384, 0, 100, -100, 50, 10);
		send_fields(16384, 0, 16384, 0, 0, 0, 0);
		send_fields(0, 5000, -16384, 1, -1, 0, 1);
		send_fields(-32768, 0, 0, 32767, -32768, 0, 20);
		send_fields(32767, -32768, 0, -32768, 32767, 32767, 65535);
		send_fields(0, 0, -32768, 0, 0, -32768, 5);
		send_fields(0, -1, 0, 0, 0, 0, 65535);
		send_fields(1, 0, 0, 0, 0, 0, 1);
		send_fields(-1, 1, 1, -1, 1, -1, 2);
		drain();

		// extremes: out-of-range accel offsets, zero scale, all-accel weight
		write_all(17'h07FFF, 17'h08000, 17'h0FFFF, 17'h10000, 17'h10000, 17'd0, 17'd0);
		send_fields(32767, 0, 0, 1000, -1000, 500, 100);
		send_fields(-32768, 32767, 0, -32768, 32767, 0, 65535);
		send_fields(0, -32768, 0, 0, 0, 0, 0);
		send_random(30);
		drain();

		// weight above one acts as pure gyro
		write_all(17'h08000, 17'h07FFF, 17'd0, 17'd0, 17'd0, 17'd65535, 17'h1FFFF);
		send_random(40);
		drain();
		write_reg(imutcf_pkg::REG_GYRO_W, 17'd65536);
		send_random(30);
		drain();

		quiet = 1'b1;
		rand_config();
		send_random(40);
		drain();
		quiet = 1'b0;

		// drive the accumulators far past the 32-bit output range
		quiet = 1'b1;
		write_all(17'd0, 17'd0, 17'h10000, 17'h10000, 17'h10000, 17'd65535, 17'd32768);
		for (int i = 0; i < 80; i++)
			send_fields(int'($urandom), int'($urandom), int'($urandom),
				32767, 32767, 32767, 65535);
		drain();
		quiet = 1'b0;

		for (int k = 0; k < 3; k++) begin
			rand_config();
			send_random(50);
			drain();
		end

		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
